FILE: rtl/mlh_pkg.sv
// shared types and constants of the multilevel hash insert block
`timescale 1ns / 1ps

package mlh_pkg;

  localparam int KEY_W      = 64;
  localparam int STATUS_W   = 2;
  localparam int LEVEL_W    = 4;
  localparam int SLOT_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_SEEDS  = 3;
  localparam int SEED_SEL_W = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MULT_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADD_A  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MULT_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADD_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MULT_C = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ADD_C  = 3'd5;

  // seed reset values
  localparam logic [KEY_W-1:0] RST_MULT_A = 64'd1;
  localparam logic [KEY_W-1:0] RST_ADD_A  = 64'd0;
  localparam logic [KEY_W-1:0] RST_MULT_B = 64'd3;
  localparam logic [KEY_W-1:0] RST_ADD_B  = 64'd1;
  localparam logic [KEY_W-1:0] RST_MULT_C = 64'd5;
  localparam logic [KEY_W-1:0] RST_ADD_C  = 64'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_HLAST,
    S_READ,
    S_CMP,
    S_EMIT
  } state_t;

endpackage

FILE: rtl/mlh_hash_unit.sv
// shared multiply-add hash unit, low bits only, registered output
`timescale 1ns / 1ps

module mlh_hash_unit #(
  parameter int HW = 9
) (
  input  logic          clk,
  input  logic [HW-1:0] mult,
  input  logic [HW-1:0] add,
  input  logic [HW-1:0] key,
  output logic [HW-1:0] hash
);

  logic [2*HW-1:0] prod;
  logic [HW-1:0]   sum;

  // only the low bits of the 64-bit wrapping hash reach any slot index
  assign prod = (2*HW)'(mult) * (2*HW)'(key);
  assign sum  = prod[HW-1:0] + add;

  always_ff @(posedge clk) begin
    hash <= sum;
  end

endmodule

FILE: rtl/mlh_slot_mem.sv
// slot store: valid mark and key per entry, one write and one registered read port
`timescale 1ns / 1ps

module mlh_slot_mem #(
  parameter int AW    = 10,
  parameter int DEPTH = 1023,
  parameter int DW    = 65
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/multilevel_hash_insert.sv
// top level: multilevel hash table insert sequencer with seed registers
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+----------------------------
//   in      | input     | in_valid / in_stall       | key
//   out     | output    | out_valid / out_stall     | status, level, slot
//   cfg     | input     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// after reset a clearing pass wipes the valid marks of all 2^MAX_LEVELS - 1
// entries, one entry a cycle; in_stall stays high meanwhile, cfg writes are
// taken anytime; each probe is one read of the slot store then one compare
// (the first probe of a freshly opened level is written at once), and the
// PROBES hashes come from one shared multiply-add one item at a time; a
// finished result waits in the output register while the next item is worked
// on, and the sequencer holds only if it is still full

module multilevel_hash_insert #(
  parameter int MAX_LEVELS = 10,
  parameter int PROBES     = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mlh_pkg::KEY_W-1:0]     key,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mlh_pkg::STATUS_W-1:0]  status,
  output logic [mlh_pkg::LEVEL_W-1:0]   level,
  output logic [mlh_pkg::SLOT_W-1:0]    slot,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mlh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlh_pkg::KEY_W-1:0]     cfg_data
);

  import mlh_pkg::*;

  localparam int TOTAL = (1 << MAX_LEVELS) - 1;
  localparam int AW    = MAX_LEVELS;
  localparam int HW    = (MAX_LEVELS > 1) ? MAX_LEVELS - 1 : 1;
  localparam int LW    = $clog2(MAX_LEVELS + 1);
  localparam int DW    = KEY_W + 1;

  localparam logic [AW-1:0]         CLR_LAST   = AW'(TOTAL - 1);
  localparam logic [LW-1:0]         LVL_FULL   = LW'(MAX_LEVELS);
  localparam logic [SEED_SEL_W-1:0] PROBE_LAST = SEED_SEL_W'(PROBES - 1);

  state_t state, state_next;

  // control registers
  logic [LW-1:0]         lvl, lvl_next;
  logic [LW-1:0]         levels_in_use, levels_next;
  logic [SEED_SEL_W-1:0] p, p_next;
  logic [SEED_SEL_W-1:0] hp, hp_next;
  logic                  opening, opening_next;
  logic [AW-1:0]         clr_addr, clr_next;
  logic                  out_valid_next;

  // payload registers
  logic [KEY_W-1:0]      key_reg;
  logic [HW-1:0]         seed_mult [NUM_SEEDS];
  logic [HW-1:0]         seed_add  [NUM_SEEDS];
  logic [HW-1:0]         hreg      [NUM_SEEDS];
  logic [SEED_SEL_W-1:0] hp_prev;
  logic [AW-1:0]         cur_addr, cur_addr_next;
  logic [STATUS_W-1:0]   res_status, res_status_next;
  logic [LEVEL_W-1:0]    res_level, res_level_next;
  logic [SLOT_W-1:0]     res_slot, res_slot_next;

  logic                  hsave;
  logic                  load_out;
  logic [HW-1:0]         hash;
  logic [HW:0]           mask_ext;
  logic [HW-1:0]         probe_slot;
  logic [AW-1:0]         probe_base;
  logic [AW-1:0]         probe_addr;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DW-1:0]         mem_wdata;
  logic [DW-1:0]         rdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  mlh_hash_unit #(
    .HW (HW)
  ) u_hash (
    .clk  (clk),
    .mult (seed_mult[hp]),
    .add  (seed_add[hp]),
    .key  (key_reg[HW-1:0]),
    .hash (hash)
  );

  mlh_slot_mem #(
    .AW    (AW),
    .DEPTH (TOTAL),
    .DW    (DW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (probe_addr),
    .rdata (rdata)
  );

  // level j starts at entry 2^j - 1 and uses the low j bits of the hash
  always_comb begin
    mask_ext   = ((HW + 1)'(1) << lvl) - (HW + 1)'(1);
    probe_slot = hreg[p] & mask_ext[HW-1:0];
    probe_base = (AW'(1) << lvl) - AW'(1);
    probe_addr = probe_base + AW'(probe_slot);
  end

  always_comb begin
    state_next      = state;
    lvl_next        = lvl;
    levels_next     = levels_in_use;
    p_next          = p;
    hp_next         = hp;
    opening_next    = opening;
    clr_next        = clr_addr;
    out_valid_next  = out_valid && out_stall;
    cur_addr_next   = cur_addr;
    res_status_next = res_status;
    res_level_next  = res_level;
    res_slot_next   = res_slot;
    hsave           = 1'b0;
    load_out        = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = cur_addr;
    mem_wdata       = {1'b1, key_reg};

    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == CLR_LAST) begin
          state_next = S_IDLE;
        end else begin
          clr_next = clr_addr + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next   = S_HASH;
          lvl_next     = '0;
          p_next       = '0;
          hp_next      = '0;
          opening_next = 1'b0;
        end
      end
      S_HASH: begin
        // the hash unit output is registered and so belongs to the previous seed select
        hsave = (hp != '0);
        if (hp == PROBE_LAST) begin
          state_next = S_HLAST;
        end else begin
          hp_next = hp + SEED_SEL_W'(1);
        end
      end
      S_HLAST: begin
        hsave      = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cur_addr_next   = probe_addr;
        res_level_next  = LEVEL_W'(lvl);
        res_slot_next   = SLOT_W'(probe_slot);
        res_status_next = ST_INSERTED;
        if (opening) begin
          // fresh level: the first probe slot is empty
          mem_we     = 1'b1;
          mem_waddr  = probe_addr;
          state_next = S_EMIT;
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (!rdata[KEY_W]) begin
          mem_we          = 1'b1;
          res_status_next = ST_INSERTED;
          state_next      = S_EMIT;
        end else if (rdata[KEY_W-1:0] == key_reg) begin
          res_status_next = ST_PRESENT;
          state_next      = S_EMIT;
        end else if (p != PROBE_LAST) begin
          p_next     = p + SEED_SEL_W'(1);
          state_next = S_READ;
        end else if (lvl + LW'(1) != levels_in_use) begin
          lvl_next   = lvl + LW'(1);
          p_next     = '0;
          state_next = S_READ;
        end else if (levels_in_use == LVL_FULL) begin
          res_status_next = ST_FULL;
          res_level_next  = '0;
          res_slot_next   = '0;
          state_next      = S_EMIT;
        end else begin
          lvl_next     = levels_in_use;
          levels_next  = levels_in_use + LW'(1);
          p_next       = '0;
          opening_next = 1'b1;
          state_next   = S_READ;
        end
      end
      S_EMIT: begin
        if (!out_valid || !out_stall) begin
          load_out       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl           <= '0;
      levels_in_use <= LW'(1);
      p             <= '0;
      hp            <= '0;
      opening       <= 1'b0;
      clr_addr      <= '0;
      out_valid     <= 1'b0;
      seed_mult[0]  <= RST_MULT_A[HW-1:0];
      seed_add[0]   <= RST_ADD_A[HW-1:0];
      seed_mult[1]  <= RST_MULT_B[HW-1:0];
      seed_add[1]   <= RST_ADD_B[HW-1:0];
      seed_mult[2]  <= RST_MULT_C[HW-1:0];
      seed_add[2]   <= RST_ADD_C[HW-1:0];
    end else begin
      lvl           <= lvl_next;
      levels_in_use <= levels_next;
      p             <= p_next;
      hp            <= hp_next;
      opening       <= opening_next;
      clr_addr      <= clr_next;
      out_valid     <= out_valid_next;
      // only the low seed bits can reach a slot index
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MULT_A: seed_mult[0] <= cfg_data[HW-1:0];
          REG_ADD_A:  seed_add[0]  <= cfg_data[HW-1:0];
          REG_MULT_B: seed_mult[1] <= cfg_data[HW-1:0];
          REG_ADD_B:  seed_add[1]  <= cfg_data[HW-1:0];
          REG_MULT_C: seed_mult[2] <= cfg_data[HW-1:0];
          REG_ADD_C:  seed_add[2]  <= cfg_data[HW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    hp_prev    <= hp;
    cur_addr   <= cur_addr_next;
    res_status <= res_status_next;
    res_level  <= res_level_next;
    res_slot   <= res_slot_next;
    if (state == S_IDLE && in_valid) begin
      key_reg <= key;
    end
    if (hsave) begin
      hreg[hp_prev] <= hash;
    end
    if (load_out) begin
      status <= res_status;
      level  <= res_level;
      slot   <= res_slot;
    end
  end

endmodule

FILE: dv/multilevel_hash_insert_checker.sv
// checker for multilevel_hash_insert: tracks the table stack and compares every result
`timescale 1ns / 1ps

module multilevel_hash_insert_checker #(
  parameter int MAX_LEVELS = 10,
  parameter int PROBES     = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [mlh_pkg::KEY_W-1:0]     key,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [mlh_pkg::STATUS_W-1:0]  status,
  input  logic [mlh_pkg::LEVEL_W-1:0]   level,
  input  logic [mlh_pkg::SLOT_W-1:0]    slot,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [mlh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlh_pkg::KEY_W-1:0]     cfg_data,
  output int                            fail_count,
  output int                            results_waiting
);

  import mlh_pkg::*;

  localparam int TOTAL_SLOTS = (1 << MAX_LEVELS) - 1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LEVEL_W-1:0]  level;
    logic [SLOT_W-1:0]   slot;
  } placement_t;

  logic [KEY_W-1:0] hash_mult [NUM_SEEDS];
  logic [KEY_W-1:0] hash_add  [NUM_SEEDS];
  int               open_levels = 1;
  bit               slot_taken [TOTAL_SLOTS];
  logic [KEY_W-1:0] slot_key   [TOTAL_SLOTS];
  placement_t       placements_due [$];
  placement_t       want;
  int               mismatches = 0;

  function automatic logic [KEY_W-1:0] probe_slot(logic [KEY_W-1:0] k, int p, int lv);
    logic [KEY_W-1:0] h;
    h = hash_mult[p] * k + hash_add[p];
    return h & ((64'd1 << lv) - 64'd1);
  endfunction

  // walks the open levels, updates the stack and returns where the key ended up
  function automatic placement_t insert_key(logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] s;
    int               e;
    int               lv;
    for (int l = 0; l < open_levels && l < MAX_LEVELS; l++) begin
      for (int p = 0; p < PROBES && p < NUM_SEEDS; p++) begin
        s = probe_slot(k, p, l);
        e = (1 << l) - 1 + int'(s);
        if (e < TOTAL_SLOTS) begin
          if (!slot_taken[e]) begin
            slot_taken[e] = 1'b1;
            slot_key[e]   = k;
            return {ST_INSERTED, l[LEVEL_W-1:0], s[SLOT_W-1:0]};
          end
          if (slot_key[e] == k) begin
            return {ST_PRESENT, l[LEVEL_W-1:0], s[SLOT_W-1:0]};
          end
        end
      end
    end
    if (open_levels >= MAX_LEVELS) begin
      return {ST_FULL, {LEVEL_W{1'b0}}, {SLOT_W{1'b0}}};
    end
    // every open level refused the key: open one more, first probe wins
    lv = open_levels;
    open_levels++;
    s = probe_slot(k, 0, lv);
    e = (1 << lv) - 1 + int'(s);
    if (e < TOTAL_SLOTS) begin
      slot_taken[e] = 1'b1;
      slot_key[e]   = k;
    end
    return {ST_INSERTED, lv[LEVEL_W-1:0], s[SLOT_W-1:0]};
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      hash_mult[0] = RST_MULT_A;
      hash_add[0]  = RST_ADD_A;
      hash_mult[1] = RST_MULT_B;
      hash_add[1]  = RST_ADD_B;
      hash_mult[2] = RST_MULT_C;
      hash_add[2]  = RST_ADD_C;
      open_levels  = 1;
      foreach (slot_taken[i]) slot_taken[i] = 1'b0;
      placements_due.delete();
      mismatches   = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MULT_A: hash_mult[0] = cfg_data;
          REG_ADD_A:  hash_add[0]  = cfg_data;
          REG_MULT_B: hash_mult[1] = cfg_data;
          REG_ADD_B:  hash_add[1]  = cfg_data;
          REG_MULT_C: hash_mult[2] = cfg_data;
          REG_ADD_C:  hash_add[2]  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        placements_due.push_back(insert_key(key));
      end
      if (out_valid && !out_stall) begin
        if (placements_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result transfer with nothing expected: status %0d level %0d slot %0d",
                     $time, status, level, slot);
          end
        end else begin
          want = placements_due.pop_front();
          if (want.status !== status || want.level !== level || want.slot !== slot) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: expected status %0d level %0d slot %0d, %s",
                       $time, want.status, want.level, want.slot,
                       $sformatf("got status %0d level %0d slot %0d", status, level, slot));
            end
          end
        end
      end
    end
    fail_count      <= mismatches;
    results_waiting <= placements_due.size();
  end

endmodule

FILE: dv/multilevel_hash_insert_test.sv
// top of the multilevel_hash_insert testbench: stimulus, stalls and verdict
`timescale 1ns / 1ps

module multilevel_hash_insert_test;
  import mlh_pkg::*;

  localparam int CYCLE_LIMIT   = 250000;
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASE_ITEMS   = 100;

  // indexes past the last seed register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [KEY_W-1:0]     ALL_ONES     = 64'hffff_ffff_ffff_ffff;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [KEY_W-1:0]     key       = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [LEVEL_W-1:0]   level;
  logic [SLOT_W-1:0]    slot;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KEY_W-1:0]     cfg_data  = '0;

  int               fail_count;
  int               results_waiting;
  bit               idle_on     = 1'b0;
  int               stall_left  = 0;
  int               cycle_count = 0;
  logic [KEY_W-1:0] sent_keys [$];

  // zero twice to see a repeat in level zero, low-bit collisions under unit multiplier
  logic [KEY_W-1:0] corner_keys [18] = '{
    64'd0, 64'd0, 64'hffff_ffff_ffff_ffff, 64'd1, 64'hffff_ffff_ffff_ffff,
    64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 64'haaaa_aaaa_aaaa_aaaa,
    64'h5555_5555_5555_5555, 64'd2, 64'd3, 64'd4, 64'h400, 64'h800, 64'hc00,
    64'h1000, 64'hffff_ffff_0000_0000, 64'd1
  };

  multilevel_hash_insert u_dut (
    .clk, .rst, .in_valid, .in_stall, .key, .out_valid, .out_stall,
    .status, .level, .slot, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  multilevel_hash_insert_checker u_check (
    .clk, .rst, .in_valid, .in_stall, .key, .out_valid, .out_stall,
    .status, .level, .slot, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .results_waiting
  );

  always #10 clk = ~clk;

  // result side back-pressure in random bursts
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [KEY_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [KEY_W-1:0] pick_seed();
    int r;
    r = $urandom_range(0, 4);
    if (r == 0) return '0;
    if (r == 1) return ALL_ONES;
    return rand64();
  endfunction

  // mostly fresh keys, plus repeats and near-repeats that collide in the low bits
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20 && sent_keys.size() != 0) begin
      return sent_keys[$urandom_range(0, sent_keys.size() - 1)];
    end
    if (r < 35 && sent_keys.size() != 0) begin
      return sent_keys[$urandom_range(0, sent_keys.size() - 1)] ^ (rand64() << 9);
    end
    if (r < 45) return 64'($urandom_range(0, 31));
    if (r < 50) return ~64'($urandom_range(0, 31));
    return rand64();
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_seeds(logic [KEY_W-1:0] mult_a, logic [KEY_W-1:0] add_a,
                            logic [KEY_W-1:0] mult_b, logic [KEY_W-1:0] add_b,
                            logic [KEY_W-1:0] mult_c, logic [KEY_W-1:0] add_c);
    write_reg(REG_MULT_A, mult_a);
    write_reg(REG_ADD_A, add_a);
    write_reg(REG_MULT_B, mult_b);
    write_reg(REG_ADD_B, add_b);
    write_reg(REG_MULT_C, mult_c);
    write_reg(REG_ADD_C, add_c);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_key(logic [KEY_W-1:0] k);
    in_valid <= 1'b1;
    key      <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_keys.push_back(k);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // lets every outstanding result through before the seeds change
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_waiting != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("multilevel_hash_insert test failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst     <= 1'b0;
    idle_on <= 1'b1;
    write_reg(REG_SPARE_LO, rand64());
    write_reg(REG_SPARE_HI, ALL_ONES);
    load_seeds(RST_MULT_A, RST_ADD_A, RST_MULT_B, RST_ADD_B, RST_MULT_C, RST_ADD_C);

    foreach (corner_keys[i]) send_key(corner_keys[i]);
    drain();

    // zero multipliers pin every key to the same probe slots in each level, so the stack fills fast
    write_reg(REG_SPARE_LO, ALL_ONES);
    load_seeds('0, ALL_ONES, '0, '0, '0, 64'h155);
    repeat (40) send_key(pick_key());
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 0) begin
        load_seeds(ALL_ONES, rand64(), ALL_ONES, ALL_ONES, ALL_ONES, '0);
      end else begin
        load_seeds(pick_seed(), pick_seed(), pick_seed(), pick_seed(), pick_seed(),
                   pick_seed());
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 25 == 0) begin
          idle_on <= (ph != 4) && ($urandom_range(0, 2) != 0);
        end
        send_key(pick_key());
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_waiting == 0) begin
      $display("multilevel_hash_insert test passed");
    end else begin
      $display("multilevel_hash_insert test failed");
    end
    $finish;
  end

endmodule
